FILE: sv/cloud_texture_sum_of_sines_core_defines.svh
// Assertion macros for the cloud texture core.
// Used by the top level only; no other dependencies.
`ifndef CLOUD_TEXTURE_SUM_OF_SINES_CORE_DEFINES_SVH
`define CLOUD_TEXTURE_SUM_OF_SINES_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define CTSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define CTSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ctss_pkg.sv
// Package for the cloud texture core: field widths, register codes,
// angle type and the elaboration-time sine table and amplitude functions.
package ctss_pkg;

  localparam int COORD_W    = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int TURN_BITS  = 25;
  localparam int SINE_W     = 16;
  localparam int AXIS_W     = 48;   // 17-bit signed freq times 32-bit coord

  localparam longint Q30_ONE    = 64'sd1 <<< 30;
  localparam longint HalfPiQ30  = 64'sd1686629713;
  localparam longint AmpDecay   = 64'sd23167;
  localparam longint TaylorDiv [5] = '{110, 72, 42, 20, 6};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONTRAST = 2'd0,
    CFG_FREQ_X   = 2'd1,
    CFG_FREQ_Y   = 2'd2
  } ctss_cfg_idx_t;

  // Angle in turns: low bits of the angle and a flag for angle <= 0
  typedef struct packed {
    logic                 neg;
    logic [TURN_BITS-1:0] mag;
  } ctss_ang_t;

  // Quarter-wave sine entry m for a table of 2^lg entries (Q1.15)
  function automatic logic signed [SINE_W-1:0] quarter_sine(input int m, input int lg);
    longint u, x, x2, t, s, e;
    u = 64'sd4 * longint'(m);
    x = (u * HalfPiQ30 + (64'sd1 <<< (lg - 1))) >>> lg;
    x2 = (x * x) >>> 30;
    t = Q30_ONE;
    for (int i = 0; i < 5; i++) begin
      t = Q30_ONE - (((x2 * t) >>> 30) / TaylorDiv[i]);
    end
    if (t < 0) t = 0;
    s = (x * t) >>> 30;
    e = (s + 64'sd16384) >>> 15;
    if (e > 64'sd32767) e = 64'sd32767;
    return SINE_W'(e);
  endfunction

  // Octave amplitude in Q15: 0.707 decay per octave
  function automatic logic [16:0] amp_coef(input int oct);
    longint c;
    c = 64'sd32768;
    for (int i = 0; i < oct; i++) begin
      c = (c * AmpDecay + 64'sd16384) >>> 15;
    end
    return 17'(c);
  endfunction

endpackage

FILE: sv/ctss_stream_if.sv
// Valid/ready channel interfaces for the cloud texture core.
// Depends on ctss_pkg for field widths.
interface ctss_in_if import ctss_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

interface ctss_out_if import ctss_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  texture_value;

  modport source (output valid, output texture_value, input ready);
  modport sink   (input valid, input texture_value, output ready);
endinterface

FILE: sv/ctss_sine.sv
// Sine of an angle in turns from a quarter-wave table, Q1.15 result.
// Depends on ctss_pkg (angle type, table function).
module ctss_sine import ctss_pkg::*; #(
  parameter int DEPTH = 512
) (
  input  ctss_ang_t                ang,
  output logic signed [SINE_W-1:0] sine
);

  localparam int L  = $clog2(DEPTH);
  localparam int QD = DEPTH / 4;

  logic [TURN_BITS-1:0]      r;
  logic [TURN_BITS:0]        rsum;
  logic [L-1:0]              idx;
  logic [1:0]                quad;
  logic [L-3:0]              j;
  logic [L-2:0]              uidx;
  logic signed [SINE_W-1:0]  qtab [QD+1];
  logic signed [SINE_W-1:0]  mag;

  // Quarter-wave table, built at elaboration
  for (genvar k = 0; k <= QD; k++) begin : g_tab
    localparam logic signed [SINE_W-1:0] Entry = quarter_sine(k, L);
    assign qtab[k] = Entry;
  end

  // Fold to magnitude, round to table index, mirror by quadrant
  always_comb begin
    r    = ang.neg ? (~ang.mag + 1'b1) : ang.mag;
    rsum = {1'b0, r} + ((TURN_BITS+1)'(1) << (TURN_BITS - 1 - L));
    idx  = rsum[TURN_BITS-1 -: L];
    quad = idx[L-1 -: 2];
    j    = idx[L-3:0];
    uidx = quad[0] ? ((L-1)'(QD) - {1'b0, j}) : {1'b0, j};
    mag  = qtab[uidx];
    sine = (quad[1] ^ ang.neg) ? -mag : mag;
  end

endmodule

FILE: sv/cloud_texture_sum_of_sines_core.sv
// Cloud texture core: 12-stage pipeline from accept to result. Throughput one
// item per cycle unless the output stalls; each stage holds one item and a stall at the
// output backs up stage by stage, so bubbles are squeezed out.
// rst_n is synchronous, active low: clears valid bits and sets contrast 0,
// freq_x and freq_y 256. SINE_ROM_DEPTH must be a power of two.
`include "cloud_texture_sum_of_sines_core_defines.svh"

module cloud_texture_sum_of_sines_core import ctss_pkg::*; #(
  parameter int NUM_OCTAVES    = 4,
  parameter int SINE_ROM_DEPTH = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ctss_in_if.sink               in_ch,
  ctss_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NS   = 12;
  localparam int N    = NUM_OCTAVES;
  localparam int AW   = AXIS_W + NUM_OCTAVES + 1;
  localparam int PRW  = 34;
  localparam int TW   = 35 + $clog2(NUM_OCTAVES + 1);
  localparam int RW   = TW - 9;
  localparam int PW   = 2 * RW;
  localparam int MW   = 32;
  localparam int N2   = NUM_OCTAVES * NUM_OCTAVES;
  localparam logic [MW:0] RECIP = (MW+1)'((64'd1 << MW) / N2);

  // Configuration registers
  logic signed [CFG_DATA_W-1:0] contrast_r;
  logic [CFG_DATA_W-1:0]        freq_x_r;
  logic [CFG_DATA_W-1:0]        freq_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contrast_r <= '0;
      freq_x_r   <= CFG_DATA_W'(256);
      freq_y_r   <= CFG_DATA_W'(256);
    end else if (cfg_we) begin
      unique case (ctss_cfg_idx_t'(cfg_index))
        CFG_CONTRAST: contrast_r <= cfg_data;
        CFG_FREQ_X:   freq_x_r   <= cfg_data;
        CFG_FREQ_Y:   freq_y_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage ready chain
  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = out_ch.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ch.ready = rdy[0];

  // Stage 0: capture coordinates
  logic signed [COORD_W-1:0] s0_x_r, s0_y_r;
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_x_r <= in_ch.coord_x;
      s0_y_r <= in_ch.coord_y;
    end
  end

  // Stage 1: axis angles freq * coord
  logic signed [AXIS_W-1:0] s1_ax_r, s1_ay_r;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_ax_r <= $signed({1'b0, freq_x_r}) * s0_x_r;
      s1_ay_r <= $signed({1'b0, freq_y_r}) * s0_y_r;
    end
  end

  // Stage 2: phase sines sin(ax*2^j), sin(ay*2^j)
  ctss_ang_t                 px_ang [N];
  ctss_ang_t                 py_ang [N];
  logic signed [SINE_W-1:0]  sx_nxt [N];
  logic signed [SINE_W-1:0]  sy_nxt [N];
  logic signed [SINE_W-1:0]  s2_sx_r [N];
  logic signed [SINE_W-1:0]  s2_sy_r [N];
  logic signed [AXIS_W-1:0]  s2_ax_r, s2_ay_r;
  logic                      ax_le0, ay_le0;

  assign ax_le0 = s1_ax_r[AXIS_W-1] || (s1_ax_r == '0);
  assign ay_le0 = s1_ay_r[AXIS_W-1] || (s1_ay_r == '0);

  for (genvar j = 0; j < N; j++) begin : g_phase
    assign px_ang[j] = '{neg: ax_le0, mag: TURN_BITS'(s1_ax_r <<< j)};
    assign py_ang[j] = '{neg: ay_le0, mag: TURN_BITS'(s1_ay_r <<< j)};
    ctss_sine #(.DEPTH(SINE_ROM_DEPTH)) u_sx (.ang(px_ang[j]), .sine(sx_nxt[j]));
    ctss_sine #(.DEPTH(SINE_ROM_DEPTH)) u_sy (.ang(py_ang[j]), .sine(sy_nxt[j]));
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_sx_r <= sx_nxt;
      s2_sy_r <= sy_nxt;
      s2_ax_r <= s1_ax_r;
      s2_ay_r <= s1_ay_r;
    end
  end

  // Stage 3: perturbed angles, one wide add each
  logic signed [AW-1:0] a1_sum [N];
  logic signed [AW-1:0] a2_sum [N];
  ctss_ang_t            a1_nxt [N];
  ctss_ang_t            a2_nxt [N];
  ctss_ang_t            s3_a1_r [N];
  ctss_ang_t            s3_a2_r [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      a1_sum[i] = ({{(AW-AXIS_W){s2_ax_r[AXIS_W-1]}}, s2_ax_r} <<< (i + 1))
                + {{(AW-SINE_W-8){s2_sy_r[i][SINE_W-1]}}, s2_sy_r[i], 8'b0};
      a2_sum[i] = ({{(AW-AXIS_W){s2_ay_r[AXIS_W-1]}}, s2_ay_r} <<< (i + 1))
                + {{(AW-SINE_W-8){s2_sx_r[i][SINE_W-1]}}, s2_sx_r[i], 8'b0};
      a1_nxt[i].neg = a1_sum[i][AW-1] || (a1_sum[i] == '0);
      a1_nxt[i].mag = a1_sum[i][TURN_BITS-1:0];
      a2_nxt[i].neg = a2_sum[i][AW-1] || (a2_sum[i] == '0);
      a2_nxt[i].mag = a2_sum[i][TURN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_a1_r <= a1_nxt;
      s3_a2_r <= a2_nxt;
    end
  end

  // Stage 4: octave sines
  logic signed [SINE_W-1:0] t1s_nxt [N];
  logic signed [SINE_W-1:0] t2s_nxt [N];
  logic signed [SINE_W-1:0] s4_t1s_r [N];
  logic signed [SINE_W-1:0] s4_t2s_r [N];

  for (genvar i = 0; i < N; i++) begin : g_term
    ctss_sine #(.DEPTH(SINE_ROM_DEPTH)) u_t1 (.ang(s3_a1_r[i]), .sine(t1s_nxt[i]));
    ctss_sine #(.DEPTH(SINE_ROM_DEPTH)) u_t2 (.ang(s3_a2_r[i]), .sine(t2s_nxt[i]));
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_t1s_r <= t1s_nxt;
      s4_t2s_r <= t2s_nxt;
    end
  end

  // Stage 5: scale by octave amplitude
  logic signed [PRW-1:0] s5_p1_r [N];
  logic signed [PRW-1:0] s5_p2_r [N];

  for (genvar i = 0; i < N; i++) begin : g_amp
    localparam logic [16:0] Amp = amp_coef(i);
    always_ff @(posedge clk) begin
      if (rdy[5]) begin
        s5_p1_r[i] <= $signed({1'b0, Amp}) * s4_t1s_r[i];
        s5_p2_r[i] <= $signed({1'b0, Amp}) * s4_t2s_r[i];
      end
    end
  end

  // Stage 6: sums in Q30 plus contrast per octave
  logic signed [TW-1:0] off_tot;
  logic signed [TW-1:0] t1_nxt, t2_nxt;
  logic signed [TW-1:0] s6_t1_r, s6_t2_r;

  always_comb begin
    off_tot = TW'(contrast_r * $signed(TW'(N))) <<< 18;
    t1_nxt  = off_tot;
    t2_nxt  = off_tot;
    for (int i = 0; i < N; i++) begin
      t1_nxt = t1_nxt + TW'(s5_p1_r[i]);
      t2_nxt = t2_nxt + TW'(s5_p2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_t1_r <= t1_nxt;
      s6_t2_r <= t2_nxt;
    end
  end

  // Stage 7: round each sum to Q20, half away from zero
  logic [TW-1:0]        m1, m2;
  logic [TW-1:0]        r1, r2;
  logic signed [RW-1:0] s7_r1_r, s7_r2_r;

  always_comb begin
    m1 = s6_t1_r[TW-1] ? TW'(-s6_t1_r) : TW'(s6_t1_r);
    m2 = s6_t2_r[TW-1] ? TW'(-s6_t2_r) : TW'(s6_t2_r);
    r1 = (m1 + TW'(512)) >> 10;
    r2 = (m2 + TW'(512)) >> 10;
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_r1_r <= s6_t1_r[TW-1] ? -$signed(RW'(r1)) : $signed(RW'(r1));
      s7_r2_r <= s6_t2_r[TW-1] ? -$signed(RW'(r2)) : $signed(RW'(r2));
    end
  end

  // Stage 8: product of the two sums
  logic signed [PW-1:0] s8_p_r;
  always_ff @(posedge clk) begin
    if (rdy[8]) s8_p_r <= s7_r1_r * s7_r2_r;
  end

  // Stage 9: magnitude, rounding offset and power-of-two part of divide
  logic [PW-1:0] pm, pm_rnd;
  logic [MW-1:0] s9_m_r;
  logic          s9_neg_r;

  always_comb begin
    pm     = s8_p_r[PW-1] ? PW'(-s8_p_r) : PW'(s8_p_r);
    pm_rnd = (pm + (PW'(N2) << 24)) >> 25;
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s9_m_r   <= pm_rnd[MW-1:0];
      s9_neg_r <= s8_p_r[PW-1];
    end
  end

  // Stage 10: divide by octave count squared via reciprocal
  logic [2*MW:0] qprod;
  logic [MW-1:0] s10_q_r, s10_m_r;
  logic          s10_neg_r;

  assign qprod = {{(MW+1){1'b0}}, s9_m_r} * {{MW{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      s10_q_r   <= qprod[2*MW-1:MW];
      s10_m_r   <= s9_m_r;
      s10_neg_r <= s9_neg_r;
    end
  end

  // Stage 11: quotient correction, sign and saturation
  logic [MW-1:0]          rem, q_fix;
  logic signed [MW:0]     res;
  logic signed [COORD_W-1:0] res_sat;
  logic signed [COORD_W-1:0] s11_val_r;

  always_comb begin
    rem   = s10_m_r - MW'(s10_q_r * MW'(N2));
    q_fix = (rem >= MW'(N2)) ? s10_q_r + 1'b1 : s10_q_r;
    res   = s10_neg_r ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
    if (res > $signed((MW+1)'(32'h7FFF_FFFF))) begin
      res_sat = 32'sh7FFF_FFFF;
    end else if (res < -$signed((MW+1)'(33'h0_8000_0000))) begin
      res_sat = 32'sh8000_0000;
    end else begin
      res_sat = res[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[11]) s11_val_r <= res_sat;
  end

  assign out_ch.valid         = v_r[NS-1];
  assign out_ch.texture_value = s11_val_r;

  // Checks on the pipeline control
  `CTSS_ASSERT_NOW(a_full_when_blocked, clk, rst_n, !in_ch.ready, (&v_r) && !out_ch.ready, "input blocked without a full, stalled pipeline")
  `CTSS_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_ch.valid && in_ch.ready, v_r[0], "accepted item missing from first stage")
  `CTSS_ASSERT_NEXT(a_drain_empty, clk, rst_n, out_ch.valid && out_ch.ready && !v_r[NS-2], !out_ch.valid, "result repeated after hand-off")

endmodule

FILE: tb/tb_top.sv
// Testbench for the cloud texture core: directed and random plane points,
// a scoreboard that predicts each texture value with its own sine table.
// Depends on ctss_pkg and the channel interfaces in ctss_stream_if.sv.
`timescale 1ns / 1ps

module tb_top;
  import ctss_pkg::*;

  localparam int OCTAVES   = 4;
  localparam int ROM_DEPTH = 512;
  localparam int LATENCY   = 12;
  localparam int WATCHDOG  = 20000;
  localparam int N_RANDOM  = 1600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ctss_in_if  in_ch ();
  ctss_out_if out_ch ();

  cloud_texture_sum_of_sines_core #(
    .NUM_OCTAVES(OCTAVES), .SINE_ROM_DEPTH(ROM_DEPTH)
  ) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predicts texture values and holds them in arrival order
  class texture_scoreboard;
    logic signed [15:0] contrast_q12;
    logic [15:0] fx, fy;
    logic signed [31:0] pending_values[$];
    int n_errors;
    longint sine_tab[ROM_DEPTH];

    function new();
      longint u, x, x2, t, s, e;
      int q, r;
      contrast_q12 = 0; fx = 256; fy = 256; n_errors = 0;
      for (int k = 0; k < ROM_DEPTH; k++) begin
        q = (4 * k) / ROM_DEPTH;
        r = (4 * k) % ROM_DEPTH;
        u = (q % 2) ? ROM_DEPTH - r : r;
        x = (u * 64'sd1686629713 + ROM_DEPTH / 2) / ROM_DEPTH;
        x2 = (x * x) >>> 30;
        t = 64'sd1 <<< 30;
        t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 110;
        t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 72;
        t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 42;
        t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 20;
        t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 6;
        if (t < 0) t = 0;
        s = (x * t) >>> 30;
        e = (s + 16384) >>> 15;
        if (e > 32767) e = 32767;
        sine_tab[k] = (q >= 2) ? -e : e;
      end
    endfunction

    function void write_reg(ctss_cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_CONTRAST: contrast_q12 = v;
        CFG_FREQ_X:   fx = v;
        CFG_FREQ_Y:   fy = v;
        default: ;
      endcase
    endfunction

    // Sine of an angle in 2^-25 turns; zero angle takes the negative branch
    function longint sin_turns(longint a);
      longint m, idx, v;
      m = (a <= 0) ? -a : a;
      m = m & ((64'sd1 <<< 25) - 1);
      idx = ((m * ROM_DEPTH + (64'sd1 <<< 24)) >>> 25) % ROM_DEPTH;
      v = sine_tab[idx];
      return (a <= 0) ? -v : v;
    endfunction

    function longint rnd_div(longint v, longint d);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + d / 2) / d;
      return (v < 0) ? -m : m;
    endfunction

    function void note_point(logic signed [31:0] cx, logic signed [31:0] cy);
      longint ax, ay, off, phx, phy, c, t1, t2, p, res;
      ax = longint'(fx) * longint'(cx);
      ay = longint'(fy) * longint'(cy);
      off = longint'(contrast_q12) * (64'sd1 <<< 18);
      phx = sin_turns(ay) * 256;
      phy = sin_turns(ax) * 256;
      c = 32768; t1 = 0; t2 = 0;
      for (int i = 0; i < OCTAVES; i++) begin
        t1 += c * sin_turns(ax * (64'sd2 <<< i) + phx) + off;
        t2 += c * sin_turns(ay * (64'sd2 <<< i) + phy) + off;
        phx = sin_turns(ay * (64'sd2 <<< i)) * 256;
        phy = sin_turns(ax * (64'sd2 <<< i)) * 256;
        c = (c * 23167 + 16384) >>> 15;
      end
      p = rnd_div(t1, 1024) * rnd_div(t2, 1024);
      res = rnd_div(p, longint'(2 * OCTAVES * OCTAVES) <<< 24);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      pending_values.push_back(32'(res));
    endfunction

    function void check_value(logic signed [31:0] got);
      logic signed [31:0] exp_v;
      if (pending_values.size() == 0) begin
        $display("%0t: texture_value unexpected, expected none, actual %0d", $time, got);
        n_errors++;
        return;
      end
      exp_v = pending_values.pop_front();
      if (got !== exp_v) begin
        $display("%0t: texture_value mismatch, expected %0d, actual %0d",
                 $time, exp_v, got);
        n_errors++;
      end
    endfunction
  endclass

  texture_scoreboard sb = new();
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    out_ch.ready = 1'b0;
  end

  // Watchdog counts cycles without any accepted item or delivered result
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side: sample at rising edge, random stall drawn per item
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = quiet_phase ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_value(out_ch.texture_value);
    end
  end

  task automatic send_point(logic signed [31:0] cx, logic signed [31:0] cy);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.coord_x <= cx;
    in_ch.coord_y <= cy;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_point(cx, cy);
  endtask

  task automatic write_reg(ctss_cfg_idx_t idx, logic [15:0] v);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // Unused index must be ignored by the block
  task automatic write_unused(logic [15:0] v);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_W'(3);
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_values.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 262143)) - 131072);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($signed($urandom_range(0, 16383)) - 8192) <<< 8;
    endcase
  endfunction

  function automatic logic [15:0] rand_freq();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1024));
      2: return 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
      default: return 16'd256;
    endcase
  endfunction

  initial begin
    logic signed [31:0] edge_vals[6];
    edge_vals = '{32'sh0, 32'sh7FFFFFFF, -32'sh80000000, 32'sh10000, -32'sh10000, 32'sh4000};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes at reset settings, then special settings
    for (int i = 0; i < 6; i++) send_point(edge_vals[i], edge_vals[5 - i]);
    send_point(32'sh00002000, 32'sh00006000);
    drain();
    write_reg(CFG_FREQ_X, 16'd0);
    write_reg(CFG_CONTRAST, 16'h7FFF);
    send_point(32'sh12345678, -32'sh00003000);
    send_point(-32'sh80000000, 32'sh7FFFFFFF);
    drain();
    write_reg(CFG_FREQ_X, 16'hFFFF);
    write_reg(CFG_FREQ_Y, 16'hFFFF);
    write_reg(CFG_CONTRAST, 16'h8000);
    for (int i = 0; i < 6; i++) send_point(edge_vals[i], edge_vals[i]);
    drain();
    write_unused(16'h1234);
    write_reg(CFG_CONTRAST, 16'h7FFF);
    write_reg(CFG_FREQ_X, 16'd256);
    write_reg(CFG_FREQ_Y, 16'd0);
    send_point(32'sh00004000, 32'sh0000C000);
    send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    drain();

    // Random: phases of settings, one phase without idling
    for (int ph = 0; ph < 16; ph++) begin
      write_reg(CFG_CONTRAST, 16'($urandom));
      write_reg(CFG_FREQ_X, rand_freq());
      write_reg(CFG_FREQ_Y, rand_freq());
      if (ph % 5 == 4) write_unused(16'($urandom));
      quiet_phase = (ph == 3);
      for (int n = 0; n < N_RANDOM / 16; n++) send_point(rand_coord(), rand_coord());
      drain();
      quiet_phase = 1'b0;
    end

    if (sb.n_errors == 0 && sb.pending_values.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/ctss_pkg.sv
sv/ctss_stream_if.sv
sv/ctss_sine.sv
sv/cloud_texture_sum_of_sines_core.sv
tb/tb_top.sv
